FILE: sv/gcl_pkg.sv
`timescale 1ns / 1ps

package gcl_pkg;

	// Number of low operand bits in use (8..32)
	localparam int OPERAND_WIDTH = 32;
	// Step counter covers one pass of the shared divider or multiplier
	localparam int CNT_W = $clog2(OPERAND_WIDTH);

	// Request beat
	typedef struct packed {
		logic [31:0] operand_a;
		logic [31:0] operand_b;
	} gcl_req_t;

	// Response beat
	typedef struct packed {
		logic [31:0] gcd_value;
		logic [63:0] lcm_value;
	} gcl_rsp_t;

	// Controller to datapath commands
	typedef struct packed {
		logic load;
		logic div_start;
		logic div_sel_lcm;
		logic div_step;
		logic euclid_next;
		logic mul_start;
		logic mul_step;
		logic rsp_load;
	} gcl_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic small_zero;
		logic op_zero;
	} gcl_sts_t;

endpackage

FILE: sv/gcl_dpath.sv
`timescale 1ns / 1ps

module gcl_dpath (
	input  logic            clk,
	input  gcl_pkg::gcl_req_t req,
	input  gcl_pkg::gcl_cmd_t cmd,
	output gcl_pkg::gcl_sts_t sts,
	output gcl_pkg::gcl_rsp_t rsp
);
	import gcl_pkg::*;

	localparam int W = OPERAND_WIDTH;

	logic [W-1:0]   a_q, b_q;
	logic [W-1:0]   big_q, small_q;
	logic [W-1:0]   n_q, d_q;
	logic [W:0]     r_q;
	logic [W-1:0]   mplier_q;
	logic [2*W-1:0] mcand_q, acc_q;
	gcl_rsp_t       rsp_q;

	logic [W-1:0]   ld_a, ld_b;
	logic [W:0]     r_sh, r_sub;
	logic           q_bit;

	// Masked operands at load
	assign ld_a = req.operand_a[W-1:0];
	assign ld_b = req.operand_b[W-1:0];

	// One restoring division step: shift in next dividend bit, trial subtract
	always_comb begin
		r_sh  = {r_q[W-1:0], n_q[W-1]};
		q_bit = (r_sh >= {1'b0, d_q});
		r_sub = q_bit ? (r_sh - {1'b0, d_q}) : r_sh;
	end

	// Operands and Euclid pair
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			a_q <= ld_a;
			b_q <= ld_b;
			if (ld_a < ld_b) begin
				big_q   <= ld_b;
				small_q <= ld_a;
			end else begin
				big_q   <= ld_a;
				small_q <= ld_b;
			end
		end else if (cmd.euclid_next) begin
			big_q   <= small_q;
			small_q <= r_q[W-1:0];
		end
	end

	// Shared divider: n_q holds dividend then quotient, r_q the remainder
	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			n_q <= cmd.div_sel_lcm ? a_q : big_q;
			d_q <= cmd.div_sel_lcm ? big_q : small_q;
			r_q <= '0;
		end else if (cmd.div_step) begin
			n_q <= {n_q[W-2:0], q_bit};
			r_q <= r_sub;
		end
	end

	// Shift-and-add multiplier for (a / gcd) * b
	always_ff @(posedge clk) begin
		if (cmd.mul_start) begin
			mplier_q <= n_q;
			mcand_q  <= {{W{1'b0}}, b_q};
			acc_q    <= '0;
		end else if (cmd.mul_step) begin
			if (mplier_q[0]) begin
				acc_q <= acc_q + mcand_q;
			end
			mcand_q  <= {mcand_q[2*W-2:0], 1'b0};
			mplier_q <= {1'b0, mplier_q[W-1:1]};
		end
	end

	// Response register
	always_ff @(posedge clk) begin
		if (cmd.rsp_load) begin
			rsp_q.gcd_value <= 32'(big_q);
			rsp_q.lcm_value <= sts.op_zero ? 64'd0 : 64'(acc_q);
		end
	end

	assign sts.small_zero = (small_q == '0);
	assign sts.op_zero    = (a_q == '0) || (b_q == '0);
	assign rsp            = rsp_q;

endmodule

FILE: sv/gcl_ctrl.sv
`timescale 1ns / 1ps

module gcl_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	input  gcl_pkg::gcl_sts_t sts,
	output gcl_pkg::gcl_cmd_t cmd
);
	import gcl_pkg::*;

	typedef enum logic [7:0] {
		S_IDLE  = 8'b00000001,
		S_TEST  = 8'b00000010,
		S_DIV   = 8'b00000100,
		S_NEXT  = 8'b00001000,
		S_LDIV  = 8'b00010000,
		S_MLOAD = 8'b00100000,
		S_MUL   = 8'b01000000,
		S_DONE  = 8'b10000000
	} state_t;

	localparam logic [CNT_W-1:0] LAST = CNT_W'(OPERAND_WIDTH - 1);

	state_t           state_q, state_d;
	logic [CNT_W-1:0] cnt_q;
	logic             rsp_valid_q;
	logic             rsp_free;
	logic             finish;
	logic             last_step;

	assign rsp_free  = !rsp_valid_q || !rsp_stall;
	assign last_step = (cnt_q == LAST);

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		finish  = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = S_TEST;
				end
			end
			S_TEST: begin
				if (!sts.small_zero) begin
					cmd.div_start = 1'b1;
					state_d       = S_DIV;
				end else if (sts.op_zero) begin
					finish = 1'b1;
				end else begin
					cmd.div_start   = 1'b1;
					cmd.div_sel_lcm = 1'b1;
					state_d         = S_LDIV;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (last_step) state_d = S_NEXT;
			end
			S_NEXT: begin
				cmd.euclid_next = 1'b1;
				state_d         = S_TEST;
			end
			S_LDIV: begin
				cmd.div_step = 1'b1;
				if (last_step) state_d = S_MLOAD;
			end
			S_MLOAD: begin
				cmd.mul_start = 1'b1;
				state_d       = S_MUL;
			end
			S_MUL: begin
				cmd.mul_step = 1'b1;
				if (last_step) state_d = S_DONE;
			end
			S_DONE: begin
				finish = 1'b1;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		// stay in the final state until the response slot frees
		if (finish && rsp_free) begin
			cmd.rsp_load = 1'b1;
			state_d      = S_IDLE;
		end
	end

	// State, step counter, response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if ((cmd.div_step || cmd.mul_step) && !last_step) begin
				cnt_q <= cnt_q + 1'b1;
			end else begin
				cnt_q <= '0;
			end
			if (cmd.rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;

endmodule

FILE: sv/gcd_lcm_unit_core.sv
`timescale 1ns / 1ps
// Channel | valid     | stall     | beat
// request | req_valid | req_stall | req (gcl_req_t: operand_a, operand_b)
// result  | rsp_valid | rsp_stall | rsp (gcl_rsp_t: gcd_value, lcm_value)
//
// One item at a time. With W = OPERAND_WIDTH, each Euclid remainder step is a
// full W-bit pass of the shared one-bit-per-cycle divider; when both operands
// are non-zero an lcm division and a W-bit shift-and-add multiply follow.
// arst_n clears the controller; a new request is taken as soon as the result
// is in the output register, which holds under rsp_stall.

module gcd_lcm_unit_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  gcl_pkg::gcl_req_t req,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output gcl_pkg::gcl_rsp_t rsp
);
	import gcl_pkg::*;

	gcl_cmd_t cmd;
	gcl_sts_t sts;

	// Sequencer
	gcl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Divider, multiplier and result register
	gcl_dpath u_dpath (
		.clk (clk),
		.req (req),
		.cmd (cmd),
		.sts (sts),
		.rsp (rsp)
	);

endmodule

FILE: sv/gcl_chk.sv
`timescale 1ns / 1ps

module gcl_chk (
	input logic              clk,
	input logic              arst_n,
	input logic              req_valid,
	input logic              req_stall,
	input gcl_pkg::gcl_req_t req,
	input logic              rsp_valid,
	input logic              rsp_stall,
	input gcl_pkg::gcl_rsp_t rsp
);
	import gcl_pkg::*;

	// A stalled result beat holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("result beat changed under stall");

	// Only one item in flight
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request taken while busy");

	// No result appears straight after a request is taken
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> !$rose(rsp_valid))
		else $error("result too early");

	// gcd zero means both operands zero, so lcm is zero too
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.gcd_value == 32'd0) |-> (rsp.lcm_value == 64'd0))
		else $error("lcm non-zero with zero gcd");

endmodule

bind gcd_lcm_unit_core gcl_chk u_gcl_chk (.*);

FILE: bench/gcd_lcm_unit_core_tb.sv
`timescale 1ns / 1ps

module gcd_lcm_unit_core_tb;
	import gcl_pkg::*;

	localparam int     RANDOM_PAIRS = 630;
	// generous watchdog bound covering worst-case pairs plus idling
	localparam longint CYCLE_LIMIT  = 5000000;
	localparam int     LONG_HOLD    = 4000;
	// drain time after the last result, to catch a stray beat
	localparam int     TAIL_CYCLES  = 2000;
	localparam int     PRINT_CAP    = 40;

	// Expected gcd/lcm beats, oldest first, and the checks against them
	class gcd_lcm_ledger;
		gcl_rsp_t expected_q[$];
		int       mismatches;
		int       checked;
		int       zero_pairs;

		function new();
			mismatches = 0;
			checked    = 0;
			zero_pairs = 0;
		endfunction

		// Euclid on the masked operands, then lcm = (a / gcd) * b
		function gcl_rsp_t predict(gcl_req_t beat);
			logic [63:0] mask;
			logic [63:0] a;
			logic [63:0] b;
			logic [63:0] big;
			logic [63:0] lesser;
			logic [63:0] rem;
			gcl_rsp_t    res;
			mask   = (64'd1 << OPERAND_WIDTH) - 64'd1;
			a      = {32'd0, beat.operand_a} & mask;
			b      = {32'd0, beat.operand_b} & mask;
			big    = a;
			lesser = b;
			if (big < lesser) begin
				big    = b;
				lesser = a;
			end
			while (lesser != 64'd0) begin
				rem    = big % lesser;
				big    = lesser;
				lesser = rem;
			end
			res.gcd_value = big[31:0];
			res.lcm_value = (a != 64'd0 && b != 64'd0) ? (a / big) * b : 64'd0;
			return res;
		endfunction

		function void note_request(gcl_req_t beat);
			if (beat.operand_a == '0 || beat.operand_b == '0)
				zero_pairs++;
			expected_q.push_back(predict(beat));
		endfunction

		task report(string msg);
			mismatches++;
			if (mismatches <= PRINT_CAP)
				$display("%0t: %s", $time, msg);
		endtask

		task check_result(gcl_rsp_t got);
			gcl_rsp_t want;
			if (expected_q.size() == 0) begin
				report($sformatf("result beat with no request waiting: gcd %0d lcm %0d",
					got.gcd_value, got.lcm_value));
			end else begin
				want = expected_q.pop_front();
				checked++;
				if (got.gcd_value !== want.gcd_value)
					report($sformatf("gcd_value got %0d, want %0d",
						got.gcd_value, want.gcd_value));
				if (got.lcm_value !== want.lcm_value)
					report($sformatf("lcm_value got %0d, want %0d",
						got.lcm_value, want.lcm_value));
			end
		endtask
	endclass

	logic     clk       = 1'b0;
	logic     arst_n    = 1'b0;
	logic     req_valid = 1'b0;
	logic     req_stall;
	gcl_req_t req       = '0;
	logic     rsp_valid;
	logic     rsp_stall = 1'b0;
	gcl_rsp_t rsp;

	// shared pacing: calm stretches drop all idling, hold_off_due asks for one long stall
	logic     calm         = 1'b0;
	logic     hold_off_due = 1'b0;
	longint   cycles       = 0;

	gcd_lcm_ledger ledger;

	gcd_lcm_unit_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycles, ledger.expected_q.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Offer one request beat; entered and left at a falling edge
	task automatic send_pair(logic [31:0] a, logic [31:0] b);
		gcl_req_t    beat;
		int unsigned gap;
		beat.operand_a = a;
		beat.operand_b = b;
		gap = calm ? 0 : $urandom_range(0, 4);
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req       <= beat;
		req_valid <= 1'b1;
		do
			@(posedge clk);
		while (req_stall);
		ledger.note_request(beat);
		@(negedge clk);
	endtask

	// Random operand pairs, weighted towards shared factors and corner shapes
	function automatic gcl_req_t random_pair();
		gcl_req_t    beat;
		logic [31:0] factor;
		int unsigned kind;
		kind           = $urandom_range(0, 9);
		beat.operand_a = $urandom();
		beat.operand_b = $urandom();
		factor         = $urandom_range(1, 65535);
		case (kind)
			3, 4: begin
				beat.operand_a = factor * $urandom_range(1, 65535);
				beat.operand_b = factor * $urandom_range(1, 65535);
			end
			5: begin
				beat.operand_a = $urandom_range(0, 255);
				beat.operand_b = $urandom_range(0, 255);
			end
			6: begin
				if ($urandom_range(0, 1))
					beat.operand_a = '0;
				else
					beat.operand_b = '0;
			end
			7: beat.operand_b = beat.operand_a >> $urandom_range(0, 31);
			8: beat.operand_b = beat.operand_a;
			9: begin
				beat.operand_a = 32'd1 << $urandom_range(0, 31);
				beat.operand_b = factor << $urandom_range(0, 16);
			end
			default: ;
		endcase
		return beat;
	endfunction

	// Request side: reset, directed pairs, random pairs, then drain
	initial begin : stimulus
		gcl_req_t beat;
		ledger = new();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// zeros, extremes, worst-case Euclid chain, bit patterns
		send_pair(32'h0000_0000, 32'h0000_0000);
		send_pair(32'h0000_0000, 32'hFFFF_FFFF);
		send_pair(32'hFFFF_FFFF, 32'h0000_0000);
		send_pair(32'h0000_0000, 32'h0000_0001);
		send_pair(32'h0000_0001, 32'h0000_0000);
		send_pair(32'h0000_0001, 32'h0000_0001);
		send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFE);
		send_pair(32'hFFFF_FFFE, 32'hFFFF_FFFF);
		send_pair(32'hFFFF_FFFF, 32'h0000_0001);
		send_pair(32'h0000_0001, 32'hFFFF_FFFF);
		send_pair(32'd2971215073, 32'd1836311903);
		send_pair(32'd1836311903, 32'd2971215073);
		send_pair(32'd4294967291, 32'd4294967279);
		send_pair(32'h8000_0000, 32'h4000_0000);
		send_pair(32'hAAAA_AAAA, 32'h5555_5555);
		send_pair(32'h1234_5678, 32'h1234_5678);
		send_pair(32'hFFFF_0000, 32'h0000_FFFF);
		send_pair(32'd60, 32'd48);
		send_pair(32'd7, 32'd13);

		for (int i = 0; i < RANDOM_PAIRS; i++) begin
			calm = ((i / 60) % 4) == 3;
			if (i == 200)
				hold_off_due = 1'b1;
			beat = random_pair();
			send_pair(beat.operand_a, beat.operand_b);
		end
		req_valid <= 1'b0;

		while (ledger.expected_q.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d operand pairs (%0d with a zero operand), %0d results checked",
			ledger.checked, ledger.zero_pairs, ledger.checked);
		$display("random idling on both sides, calm stretches, one %0d-cycle result stall",
			LONG_HOLD);
		if (ledger.mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("%0d mismatches", ledger.mismatches);
			$display("end of test: mismatches");
		end
		$finish;
	end

	// Result side: random stalls, one long hold-off, check every beat taken
	initial begin : sink
		int unsigned hold;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (hold_off_due) begin
				hold_off_due = 1'b0;
				hold         = LONG_HOLD;
			end else begin
				hold = calm ? 0 : $urandom_range(0, 4);
			end
			if (hold != 0) begin
				rsp_stall <= 1'b1;
				repeat (hold) @(negedge clk);
			end
			rsp_stall <= 1'b0;
			do
				@(posedge clk);
			while (!rsp_valid);
			ledger.check_result(rsp);
			@(negedge clk);
		end
	end

endmodule

FILE: files.f
sv/gcl_pkg.sv
sv/gcl_dpath.sv
sv/gcl_ctrl.sv
sv/gcd_lcm_unit_core.sv
sv/gcl_chk.sv
bench/gcd_lcm_unit_core_tb.sv
